FILE: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Command codes, cell operations and the control beat shared by the cell row.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int unsigned ValueWidth = 32;
   localparam int unsigned CountOutWidth = 5;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_PEEK   = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   // The operation that every cell of the row performs.
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_SHIFT  = 2'd2
   } op_type;

   typedef struct packed {
      op_type                         op;
      logic signed [ValueWidth-1:0]   value;
   } ctrl_type;

endpackage

FILE: sv/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one queue slot and trades entries with its two neighbors.
// ----------------------------------------------------------------------------
module spq_cell
   import spq_pkg::*;
(
   input  logic                          clock,
   input  ctrl_type                      ctrl,
   input  logic                          occupied,
   input  logic signed [ValueWidth-1:0]  prev_entry,
   input  logic                          prev_below,
   input  logic signed [ValueWidth-1:0]  next_entry,
   output logic signed [ValueWidth-1:0]  entry,
   output logic                          below
);

   logic signed [ValueWidth-1:0] entry_ff;
   logic signed [ValueWidth-1:0] entry_in;

   // A cell is "below" the new value when it is empty or strictly smaller;
   // the row is sorted, so these flags form a thermometer from the tail.
   assign below = !occupied || (entry_ff < ctrl.value);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (below) begin
               entry_in = prev_below ? prev_entry : ctrl.value;
            end
         end
         OP_SHIFT: entry_in = next_entry;
         default:  entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: sv/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded max-priority queue of signed values kept in descending order in a
// row of cells; insert, remove, peek and clear, one result per command.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                    Direction  Handshake
//   request   start, busy, req_cmd, req_value          in         start & !busy
//   response  rsp_strobe, rsp_result_value, rsp_ok,    out        strobe, 1 cycle
//             rsp_entry_count, rsp_is_empty_flag,
//             rsp_is_full_flag
//
// For every command, all cells decide their next entry in parallel from their
// own compare and their neighbors' data, so the row is updated at the same
// edge that accepts the beat. The response beat appears in the cycle
// after acceptance, for exactly one cycle. The queue never pushes back, so busy
// stays low and a new command may follow in every cycle. Reset clears the count
// and the response strobe; slot contents are unknown until written and are
// never looked at beyond the count.
//
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int unsigned CAPACITY = 16
)
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_cmd,
   input  logic signed [ValueWidth-1:0]     req_value,
   output logic                             rsp_strobe,
   output logic signed [ValueWidth-1:0]     rsp_result_value,
   output logic                             rsp_ok,
   output logic [CountOutWidth-1:0]         rsp_entry_count,
   output logic                             rsp_is_empty_flag,
   output logic                             rsp_is_full_flag
);

   localparam int unsigned CountWidth = $clog2(CAPACITY + 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(CAPACITY);

   cmd_type                          cmd;
   logic                             accept;
   logic                             empty;
   logic                             full;
   ctrl_type                         ctrl;

   logic [CountWidth-1:0]            count_ff;
   logic [CountWidth-1:0]            count_in;

   logic                             rsp_strobe_ff;
   logic signed [ValueWidth-1:0]     rsp_result_value_ff;
   logic signed [ValueWidth-1:0]     result_value_in;
   logic                             rsp_ok_ff;
   logic                             ok_in;
   logic [CountOutWidth-1:0]         rsp_entry_count_ff;
   logic                             rsp_is_empty_flag_ff;
   logic                             rsp_is_full_flag_ff;

   logic signed [ValueWidth-1:0]     entry_w [CAPACITY];
   logic                             below_w [CAPACITY];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign cmd    = cmd_type'(req_cmd);
   assign empty  = (count_ff == '0);
   assign full   = (count_ff == CountFull);

   // Command decoder: turns the request into one operation for the whole
   // row, the new count and the response fields. An insert into a full queue
   // and a remove from an empty one leave the row alone.
   always_comb begin
      ctrl.op         = OP_HOLD;
      ctrl.value      = req_value;
      count_in        = count_ff;
      result_value_in = '0;
      ok_in           = 1'b1;
      if (accept) begin
         unique case (cmd)
            CMD_INSERT: begin
               if (full) begin
                  ok_in = 1'b0;
               end else begin
                  ctrl.op  = OP_INSERT;
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_REMOVE: begin
               if (empty) begin
                  result_value_in = -32'sd1;
                  ok_in           = 1'b0;
               end else begin
                  result_value_in = entry_w[0];
                  ctrl.op         = OP_SHIFT;
                  count_in        = count_ff - 1'b1;
               end
            end
            CMD_PEEK: begin
               if (empty) begin
                  result_value_in = -32'sd1;
                  ok_in           = 1'b0;
               end else begin
                  result_value_in = entry_w[0];
               end
            end
            CMD_CLEAR: count_in = '0;
            default:   count_in = count_ff;
         endcase
      end
   end

   // The cell row. Slot 0 holds the largest value; a slot counts as occupied
   // when its index is below the stored count.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                          occupied;
      logic signed [ValueWidth-1:0]  prev_entry;
      logic                          prev_below;
      logic signed [ValueWidth-1:0]  next_entry;

      assign occupied = (count_ff > CountWidth'(i));

      if (i == 0) begin : g_head
         assign prev_entry = req_value;
         assign prev_below = 1'b0;
      end else begin : g_body
         assign prev_entry = entry_w[i-1];
         assign prev_below = below_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_entry = entry_w[i];
      end else begin : g_mid
         assign next_entry = entry_w[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (occupied),
         .prev_entry (prev_entry),
         .prev_below (prev_below),
         .next_entry (next_entry),
         .entry      (entry_w[i]),
         .below      (below_w[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_value_ff  <= result_value_in;
      rsp_ok_ff            <= ok_in;
      rsp_entry_count_ff   <= CountOutWidth'(count_in);
      rsp_is_empty_flag_ff <= (count_in == '0);
      rsp_is_full_flag_ff  <= (count_in == CountFull);
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_result_value  = rsp_result_value_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_entry_count   = rsp_entry_count_ff;
   assign rsp_is_empty_flag = rsp_is_empty_flag_ff;
   assign rsp_is_full_flag  = rsp_is_full_flag_ff;

   // The count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountFull)
      else $error("stored count above capacity");

   // Every accepted command yields exactly one response beat in the next cycle.
   a_one_response: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted command without response");

   // A refused insert happens only when the queue was full and keeps the count.
   a_refused_insert: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd == CMD_INSERT && full) |=> (!rsp_ok && count_ff == $past(count_ff)))
      else $error("insert refused without a full queue");

   // A clear always leaves an empty queue behind.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd == CMD_CLEAR) |=> (count_ff == '0 && rsp_is_empty_flag))
      else $error("clear did not empty the queue");

   // The head of the row is the largest stored value.
   a_head_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff > CountWidth'(1)) |-> (entry_w[0] >= entry_w[1]))
      else $error("head slot out of order");

endmodule
